// ===== design/ftnb_pkg.sv =====
package ftnb_pkg;

   // Significant bits kept in the largest cross product magnitude before squaring.
   localparam int SCALE_BITS = 30;

   localparam logic KIND_VERTEX = 1'b0;
   localparam logic KIND_BOX    = 1'b1;

   // Texture corners: (0,0), (1,0) and (0.5,1).
   localparam logic [1:0] TEX_ORIGIN = 2'd0;
   localparam logic [1:0] TEX_RIGHT  = 2'd1;
   localparam logic [1:0] TEX_APEX   = 2'd2;

endpackage

// ===== design/ftnb_front.sv =====
module ftnb_front #(
   parameter int COORD_BITS = 24
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [12*COORD_BITS-1:0]  face,
   input  logic                      queue_full,
   output logic                      push,
   output logic [18*COORD_BITS:0]    push_data
);
   localparam int CB = COORD_BITS;

   logic                 box_valid_ff;
   logic signed [CB-1:0] box_min_ff [3];
   logic signed [CB-1:0] box_max_ff [3];
   logic signed [CB-1:0] box_min_in [3];
   logic signed [CB-1:0] box_max_in [3];
   logic signed [CB-1:0] pt [4][3];
   logic                 is_tri;

   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         for (int i = 0; i < 3; i++) begin
            pt[c][i] = signed'(face[(c*3+i)*CB +: CB]);
         end
      end
      is_tri = 1'b1;
      for (int i = 0; i < 3; i++) begin
         if (pt[2][i] != pt[3][i]) begin
            is_tri = 1'b0;
         end
      end
      // The first face after reset starts the box from its own corner 0.
      for (int i = 0; i < 3; i++) begin
         box_min_in[i] = box_valid_ff ? box_min_ff[i] : pt[0][i];
         box_max_in[i] = box_valid_ff ? box_max_ff[i] : pt[0][i];
         for (int c = 0; c < 4; c++) begin
            if (pt[c][i] < box_min_in[i]) begin
               box_min_in[i] = pt[c][i];
            end
            if (pt[c][i] > box_max_in[i]) begin
               box_max_in[i] = pt[c][i];
            end
         end
      end
      push_data = {is_tri,
                   box_max_in[2], box_max_in[1], box_max_in[0],
                   box_min_in[2], box_min_in[1], box_min_in[0],
                   face};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         box_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            box_min_ff[i] <= '0;
            box_max_ff[i] <= '0;
         end
      end else if (push) begin
         box_valid_ff <= 1'b1;
         for (int i = 0; i < 3; i++) begin
            box_min_ff[i] <= box_min_in[i];
            box_max_ff[i] <= box_max_in[i];
         end
      end
   end

endmodule

// ===== design/ftnb_fifo.sv =====
module ftnb_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff;
   logic [AW-1:0]    rd_ptr_ff;
   logic [NW-1:0]    count_ff;

   assign full      = (count_ff == NW'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            entry_ff[wr_ptr_ff] <= push_data;
            wr_ptr_ff <= (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== design/ftnb_normal.sv =====
module ftnb_normal #(
   parameter int COORD_BITS       = 24,
   parameter int NORMAL_FRAC_BITS = 14
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [3*COORD_BITS-1:0]  p0,
   input  logic [3*COORD_BITS-1:0]  p1,
   input  logic [3*COORD_BITS-1:0]  p3,
   output logic                     done,
   output logic [3*COORD_BITS-1:0]  nrm
);
   import ftnb_pkg::*;

   localparam int CB  = COORD_BITS;
   localparam int F   = NORMAL_FRAC_BITS;
   localparam int DW  = CB + 1;
   localparam int PW  = 2 * DW;
   localparam int CW  = PW + 1;
   localparam int SW  = (CW > SCALE_BITS) ? CW : SCALE_BITS;
   localparam int LW  = SCALE_BITS + 1;
   localparam int RW  = 2 * LW;
   localparam int QW  = F + 1;
   localparam int NW  = SCALE_BITS + QW;
   localparam int STW = $clog2(LW);

   typedef enum logic [3:0] {
      S_IDLE, S_PROD, S_MAG, S_SCALE, S_SQ, S_SQRT, S_DIV_INIT, S_DIV, S_STORE
   } state_type;

   state_type            state_ff;
   logic [STW-1:0]       step_ff;
   logic [1:0]           comp_ff;
   logic signed [DW-1:0] d1_ff [3];
   logic signed [DW-1:0] d2_ff [3];
   logic signed [CW-1:0] c_ff [3];
   logic [SW-1:0]        m_ff [3];
   logic                 neg_ff [3];
   logic [RW-1:0]        sum_ff;
   logic [LW-1:0]        root_ff;
   logic [LW+2:0]        rem_ff;
   logic [LW-1:0]        dr_ff;
   logic [QW-1:0]        qsh_ff;
   logic [CB-1:0]        nrm_ff [3];
   logic                 done_ff;

   logic signed [DW-1:0]   d1_in [3];
   logic signed [DW-1:0]   d2_in [3];
   logic signed [DW-1:0]   opa;
   logic signed [DW-1:0]   opb;
   logic signed [PW-1:0]   prod;
   logic [1:0]             pidx;
   logic [CW-1:0]          cmag [3];
   logic [SW-1:0]          orv;
   logic [SCALE_BITS-1:0]  s_sel;
   logic [2*SCALE_BITS-1:0] sq;
   logic [LW+2:0]          remsh;
   logic [LW+2:0]          trial;
   logic [NW-1:0]          n_val;
   logic [LW:0]            rem2;
   logic                   ge;
   logic signed [QW:0]     qs;
   logic signed [QW:0]     nv;
   logic signed [63:0]     nv_wide;

   assign done = done_ff;
   assign nrm  = {nrm_ff[2], nrm_ff[1], nrm_ff[0]};
   assign pidx = step_ff[2:1];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         d1_in[i] = DW'(signed'(p1[i*CB +: CB])) - DW'(signed'(p0[i*CB +: CB]));
         d2_in[i] = DW'(signed'(p3[i*CB +: CB])) - DW'(signed'(p0[i*CB +: CB]));
         cmag[i]  = c_ff[i][CW-1] ? CW'(-c_ff[i]) : CW'(c_ff[i]);
      end
      // Cross product terms, two products per component, second one subtracted.
      case (step_ff[2:0])
         3'd0:    begin opa = d1_ff[1]; opb = d2_ff[2]; end
         3'd1:    begin opa = d1_ff[2]; opb = d2_ff[1]; end
         3'd2:    begin opa = d1_ff[2]; opb = d2_ff[0]; end
         3'd3:    begin opa = d1_ff[0]; opb = d2_ff[2]; end
         3'd4:    begin opa = d1_ff[0]; opb = d2_ff[1]; end
         3'd5:    begin opa = d1_ff[1]; opb = d2_ff[0]; end
         default: begin opa = d1_ff[0]; opb = d2_ff[0]; end
      endcase
      prod  = opa * opb;
      orv   = m_ff[0] | m_ff[1] | m_ff[2];
      s_sel = m_ff[comp_ff][SCALE_BITS-1:0];
      sq    = s_sel * s_sel;
      remsh = {rem_ff[LW:0], sum_ff[RW-1:RW-2]};
      trial = {1'b0, root_ff, 2'b01};
      n_val = NW'({s_sel, {F{1'b0}}}) + NW'(root_ff >> 1);
      rem2  = {dr_ff, qsh_ff[QW-1]};
      ge    = (rem2 >= {1'b0, root_ff});
      qs    = signed'({1'b0, qsh_ff});
      nv    = neg_ff[comp_ff] ? -qs : qs;
      nv_wide = 64'(nv);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
         comp_ff  <= '0;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  for (int i = 0; i < 3; i++) begin
                     d1_ff[i] <= d1_in[i];
                     d2_ff[i] <= d2_in[i];
                  end
                  step_ff  <= '0;
                  state_ff <= S_PROD;
               end
            end
            S_PROD: begin
               c_ff[pidx] <= step_ff[0] ? c_ff[pidx] - CW'(prod) : CW'(prod);
               if (step_ff == STW'(5)) begin
                  state_ff <= S_MAG;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            S_MAG: begin
               for (int i = 0; i < 3; i++) begin
                  neg_ff[i] <= c_ff[i][CW-1];
                  m_ff[i]   <= SW'(cmag[i]);
               end
               state_ff <= S_SCALE;
            end
            S_SCALE: begin
               // One bit of normalization per cycle until the largest
               // magnitude has exactly SCALE_BITS significant bits.
               if (orv == '0) begin
                  for (int i = 0; i < 3; i++) begin
                     nrm_ff[i] <= '0;
                  end
                  done_ff  <= 1'b1;
                  state_ff <= S_IDLE;
               end else if ((orv >> SCALE_BITS) != '0) begin
                  for (int i = 0; i < 3; i++) begin
                     m_ff[i] <= m_ff[i] >> 1;
                  end
               end else if (!orv[SCALE_BITS-1]) begin
                  for (int i = 0; i < 3; i++) begin
                     m_ff[i] <= m_ff[i] << 1;
                  end
               end else begin
                  comp_ff  <= '0;
                  sum_ff   <= '0;
                  state_ff <= S_SQ;
               end
            end
            S_SQ: begin
               sum_ff <= sum_ff + RW'(sq);
               if (comp_ff == 2'd2) begin
                  step_ff  <= '0;
                  rem_ff   <= '0;
                  root_ff  <= '0;
                  state_ff <= S_SQRT;
               end else begin
                  comp_ff <= comp_ff + 1'b1;
               end
            end
            S_SQRT: begin
               sum_ff <= sum_ff << 2;
               if (remsh >= trial) begin
                  rem_ff  <= remsh - trial;
                  root_ff <= {root_ff[LW-2:0], 1'b1};
               end else begin
                  rem_ff  <= remsh;
                  root_ff <= {root_ff[LW-2:0], 1'b0};
               end
               if (step_ff == STW'(LW - 1)) begin
                  comp_ff  <= '0;
                  state_ff <= S_DIV_INIT;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            S_DIV_INIT: begin
               // The quotient never exceeds 2^F, so the top bits of the
               // dividend already sit below the divisor.
               dr_ff    <= LW'(n_val >> QW);
               qsh_ff   <= n_val[QW-1:0];
               step_ff  <= '0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               dr_ff  <= ge ? LW'(rem2 - {1'b0, root_ff}) : LW'(rem2);
               qsh_ff <= {qsh_ff[QW-2:0], ge};
               if (step_ff == STW'(QW - 1)) begin
                  state_ff <= S_STORE;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            S_STORE: begin
               nrm_ff[comp_ff] <= nv_wide[CB-1:0];
               if (comp_ff == 2'd2) begin
                  done_ff  <= 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  comp_ff  <= comp_ff + 1'b1;
                  state_ff <= S_DIV_INIT;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ===== design/ftnb_back.sv =====
module ftnb_back #(
   parameter int COORD_BITS       = 24,
   parameter int NORMAL_FRAC_BITS = 14
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      ent_valid,
   input  logic [18*COORD_BITS:0]    ent_data,
   output logic                      ent_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_kind,
   output logic [COORD_BITS-1:0]     rsp_a_x,
   output logic [COORD_BITS-1:0]     rsp_a_y,
   output logic [COORD_BITS-1:0]     rsp_a_z,
   output logic [COORD_BITS-1:0]     rsp_b_x,
   output logic [COORD_BITS-1:0]     rsp_b_y,
   output logic [COORD_BITS-1:0]     rsp_b_z,
   output logic [1:0]                rsp_tex_corner,
   output logic                      rsp_last
);
   import ftnb_pkg::*;

   localparam int CB = COORD_BITS;
   localparam int VW = 3 * CB;
   localparam int EW = 18 * CB + 1;

   typedef enum logic [1:0] {B_IDLE, B_NORM, B_EMIT} state_type;

   state_type      state_ff;
   logic [EW-1:0]  ent_ff;
   logic [2:0]     idx_ff;
   logic           rsp_valid_ff;
   logic           kind_ff;
   logic [VW-1:0]  a_ff;
   logic [VW-1:0]  b_ff;
   logic [1:0]     tex_ff;
   logic           last_ff;

   logic           nu_done;
   logic [VW-1:0]  nu_nrm;
   logic [VW-1:0]  corner [4];
   logic [1:0]     csel;
   logic [1:0]     tex_sel;
   logic           is_tri;
   logic           is_box;

   assign ent_pop = (state_ff == B_IDLE) && ent_valid;

   ftnb_normal #(
      .COORD_BITS       (COORD_BITS),
      .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
   ) u_normal (
      .clock (clock),
      .reset (reset),
      .start (ent_pop),
      .p0    (ent_data[0*VW +: VW]),
      .p1    (ent_data[1*VW +: VW]),
      .p3    (ent_data[3*VW +: VW]),
      .done  (nu_done),
      .nrm   (nu_nrm)
   );

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         corner[c] = ent_ff[c*VW +: VW];
      end
      is_tri = ent_ff[EW-1];
      // The quad's second triangle is corners 2, 3, 0.
      case (idx_ff)
         3'd0:    begin csel = 2'd0; tex_sel = TEX_ORIGIN; end
         3'd1:    begin csel = 2'd1; tex_sel = TEX_RIGHT;  end
         3'd2:    begin csel = 2'd2; tex_sel = TEX_APEX;   end
         3'd3:    begin csel = 2'd2; tex_sel = TEX_ORIGIN; end
         3'd4:    begin csel = 2'd3; tex_sel = TEX_RIGHT;  end
         3'd5:    begin csel = 2'd0; tex_sel = TEX_APEX;   end
         default: begin csel = 2'd0; tex_sel = TEX_ORIGIN; end
      endcase
      is_box = is_tri ? (idx_ff == 3'd3) : (idx_ff == 3'd6);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && state_ff != B_EMIT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            B_IDLE: begin
               if (ent_valid) begin
                  ent_ff   <= ent_data;
                  state_ff <= B_NORM;
               end
            end
            B_NORM: begin
               if (nu_done) begin
                  idx_ff   <= '0;
                  state_ff <= B_EMIT;
               end
            end
            B_EMIT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  if (is_box) begin
                     kind_ff  <= KIND_BOX;
                     a_ff     <= ent_ff[12*CB +: VW];
                     b_ff     <= ent_ff[15*CB +: VW];
                     tex_ff   <= TEX_ORIGIN;
                     last_ff  <= 1'b1;
                     state_ff <= B_IDLE;
                  end else begin
                     kind_ff <= KIND_VERTEX;
                     a_ff    <= corner[csel];
                     b_ff    <= nu_nrm;
                     tex_ff  <= tex_sel;
                     last_ff <= 1'b0;
                  end
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_a_x        = a_ff[0*CB +: CB];
   assign rsp_a_y        = a_ff[1*CB +: CB];
   assign rsp_a_z        = a_ff[2*CB +: CB];
   assign rsp_b_x        = b_ff[0*CB +: CB];
   assign rsp_b_y        = b_ff[1*CB +: CB];
   assign rsp_b_z        = b_ff[2*CB +: CB];
   assign rsp_tex_corner = tex_ff;
   assign rsp_last       = last_ff;

endmodule

// ===== design/face_triangulate_normal_bbox.sv =====
// Splits four-corner faces into triangles and tags every vertex with the
// unit face normal and a texture corner; each face ends with a bounding box
// result holding the running min and max of all corners since reset.
// Input channel req_*: one face per transaction. Result channel rsp_*: one
// vertex or box per transaction, rsp_last marks the box that closes a face.
// A triangle face (corner 2 equal to corner 3) gives 4 results, a quad 7.
// The front takes a face whenever the queue is not full, updates the box
// and queues it in a two-entry queue, so up to two faces are taken while
// the back is busy. The back computes the normal in a shared sequential
// unit: cross product, magnitudes, normalizing shifts, squares, square
// root and a division per component, or a zero normal for a degenerate
// face. The results then leave at one per cycle while rsp_ready is high,
// and the back takes no new face before it has issued the last one's box.
// Reset clears the box, the queue and all handshake state. When rsp_ready is
// low the current result holds in the output register; the back waits, and
// req_ready falls once the queue is full.
module face_triangulate_normal_bbox #(
   parameter int COORD_BITS       = 24,
   parameter int NORMAL_FRAC_BITS = 14
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [COORD_BITS-1:0] req_v0_x,
   input  logic [COORD_BITS-1:0] req_v0_y,
   input  logic [COORD_BITS-1:0] req_v0_z,
   input  logic [COORD_BITS-1:0] req_v1_x,
   input  logic [COORD_BITS-1:0] req_v1_y,
   input  logic [COORD_BITS-1:0] req_v1_z,
   input  logic [COORD_BITS-1:0] req_v2_x,
   input  logic [COORD_BITS-1:0] req_v2_y,
   input  logic [COORD_BITS-1:0] req_v2_z,
   input  logic [COORD_BITS-1:0] req_v3_x,
   input  logic [COORD_BITS-1:0] req_v3_y,
   input  logic [COORD_BITS-1:0] req_v3_z,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_kind,
   output logic [COORD_BITS-1:0] rsp_a_x,
   output logic [COORD_BITS-1:0] rsp_a_y,
   output logic [COORD_BITS-1:0] rsp_a_z,
   output logic [COORD_BITS-1:0] rsp_b_x,
   output logic [COORD_BITS-1:0] rsp_b_y,
   output logic [COORD_BITS-1:0] rsp_b_z,
   output logic [1:0]            rsp_tex_corner,
   output logic                  rsp_last
);
   localparam int EW          = 18 * COORD_BITS + 1;
   localparam int QUEUE_DEPTH = 2;

   logic [12*COORD_BITS-1:0] face;
   logic                     push;
   logic [EW-1:0]            push_data;
   logic                     queue_full;
   logic                     ent_valid;
   logic [EW-1:0]            ent_data;
   logic                     ent_pop;

   assign face = {req_v3_z, req_v3_y, req_v3_x, req_v2_z, req_v2_y, req_v2_x,
                  req_v1_z, req_v1_y, req_v1_x, req_v0_z, req_v0_y, req_v0_x};

   ftnb_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .face       (face),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   ftnb_fifo #(
      .WIDTH (EW),
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (ent_pop),
      .pop_valid (ent_valid),
      .pop_data  (ent_data)
   );

   ftnb_back #(
      .COORD_BITS       (COORD_BITS),
      .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .ent_valid      (ent_valid),
      .ent_data       (ent_data),
      .ent_pop        (ent_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_a_x        (rsp_a_x),
      .rsp_a_y        (rsp_a_y),
      .rsp_a_z        (rsp_a_z),
      .rsp_b_x        (rsp_b_x),
      .rsp_b_y        (rsp_b_y),
      .rsp_b_z        (rsp_b_z),
      .rsp_tex_corner (rsp_tex_corner),
      .rsp_last       (rsp_last)
   );

endmodule

// ===== bench/tb_face_triangulate_normal_bbox.sv =====
`timescale 1ns / 1ps

module tb_face_triangulate_normal_bbox;
   import ftnb_pkg::*;

   localparam int CW = 24;
   localparam int NF = 14;
   localparam int N_RANDOM = 96;

   typedef logic signed [CW-1:0] coord_type;

   typedef struct {
      coord_type c [4][3];
   } face_type;

   typedef struct {
      logic       kind;
      coord_type  a [3];
      coord_type  b [3];
      logic [1:0] tex;
      logic       last;
   } vtx_out_type;

   typedef struct {
      face_type  f;
      bit        fixed;
      coord_type nrm [3];
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   coord_type req_c [4][3];
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_kind;
   logic [CW-1:0] rsp_a_x, rsp_a_y, rsp_a_z, rsp_b_x, rsp_b_y, rsp_b_z;
   logic [1:0] rsp_tex_corner;
   logic rsp_last;

   vtx_out_type expected_out [$];
   row_type     face_rows [$];
   bit          box_seen;
   coord_type   box_lo [3];
   coord_type   box_hi [3];
   int          mismatches = 0;
   int          results_taken = 0;
   bit          sending_done = 1'b0;

   initial begin
      for (int c = 0; c < 4; c++)
         for (int i = 0; i < 3; i++)
            req_c[c][i] = '0;
   end

   face_triangulate_normal_bbox #(.COORD_BITS(CW), .NORMAL_FRAC_BITS(NF)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_v0_x(req_c[0][0]), .req_v0_y(req_c[0][1]), .req_v0_z(req_c[0][2]),
      .req_v1_x(req_c[1][0]), .req_v1_y(req_c[1][1]), .req_v1_z(req_c[1][2]),
      .req_v2_x(req_c[2][0]), .req_v2_y(req_c[2][1]), .req_v2_z(req_c[2][2]),
      .req_v3_x(req_c[3][0]), .req_v3_y(req_c[3][1]), .req_v3_z(req_c[3][2]),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_kind(rsp_kind),
      .rsp_a_x(rsp_a_x), .rsp_a_y(rsp_a_y), .rsp_a_z(rsp_a_z),
      .rsp_b_x(rsp_b_x), .rsp_b_y(rsp_b_y), .rsp_b_z(rsp_b_z),
      .rsp_tex_corner(rsp_tex_corner), .rsp_last(rsp_last)
   );

   always #1 clock = ~clock;

   initial begin
      #2_000_000;
      $display("face_triangulate_normal_bbox test failed");
      $finish;
   end

   // Exact cross product, scaled so the largest magnitude has 30 significant
   // bits, then divided by the truncated length with rounding.
   function automatic void unit_normal(input face_type f, output coord_type n [3]);
      logic signed [71:0] d1 [3], d2 [3], cr [3];
      logic [71:0] mg [3];
      bit ng [3];
      int bl, k;
      logic [63:0] s [3], sum, len, bitv, rem, q;
      bl = 0;
      for (int i = 0; i < 3; i++) begin
         d1[i] = 72'(f.c[1][i]) - 72'(f.c[0][i]);
         d2[i] = 72'(f.c[3][i]) - 72'(f.c[0][i]);
      end
      cr[0] = d1[1] * d2[2] - d1[2] * d2[1];
      cr[1] = d1[2] * d2[0] - d1[0] * d2[2];
      cr[2] = d1[0] * d2[1] - d1[1] * d2[0];
      for (int i = 0; i < 3; i++) begin
         ng[i] = cr[i] < 0;
         mg[i] = ng[i] ? -cr[i] : cr[i];
         for (int j = 71; j >= 0; j--)
            if (mg[i][j] && j + 1 > bl) begin
               bl = j + 1;
               break;
            end
      end
      if (bl == 0) begin
         for (int i = 0; i < 3; i++) n[i] = '0;
         return;
      end
      k = bl - 30;
      sum = '0;
      for (int i = 0; i < 3; i++) begin
         s[i] = (k > 0) ? 64'(mg[i] >> k) : 64'(mg[i] << (-k));
         sum += s[i] * s[i];
      end
      rem = sum;
      len = '0;
      bitv = 64'd1 << 62;
      while (bitv > rem) bitv >>= 2;
      while (bitv != 0) begin
         if (rem >= len + bitv) begin
            rem -= len + bitv;
            len = (len >> 1) + bitv;
         end else begin
            len >>= 1;
         end
         bitv >>= 2;
      end
      for (int i = 0; i < 3; i++) begin
         q = ((s[i] << NF) + (len >> 1)) / len;
         n[i] = ng[i] ? coord_type'(-q) : coord_type'(q);
      end
   endfunction

   function automatic vtx_out_type vertex_out(input coord_type p [3],
                                              input coord_type n [3],
                                              input logic [1:0] t);
      vtx_out_type v;
      v.kind = KIND_VERTEX;
      v.a = p;
      v.b = n;
      v.tex = t;
      v.last = 1'b0;
      return v;
   endfunction

   task automatic expect_result(input vtx_out_type v);
      expected_out = {expected_out, v};
   endtask

   // Updates the running box and queues every result the face causes.
   task automatic queue_face_results(input row_type r);
      coord_type n [3];
      vtx_out_type bx;
      bit is_tri;
      is_tri = 1'b1;
      for (int c = 0; c < 4; c++)
         for (int i = 0; i < 3; i++) begin
            if (!box_seen && c == 0) begin
               box_lo[i] = r.f.c[0][i];
               box_hi[i] = r.f.c[0][i];
            end
            if (r.f.c[c][i] < box_lo[i]) box_lo[i] = r.f.c[c][i];
            if (r.f.c[c][i] > box_hi[i]) box_hi[i] = r.f.c[c][i];
         end
      box_seen = 1'b1;
      for (int i = 0; i < 3; i++)
         if (r.f.c[2][i] != r.f.c[3][i]) is_tri = 1'b0;
      if (r.fixed) n = r.nrm;
      else unit_normal(r.f, n);
      expect_result(vertex_out(r.f.c[0], n, TEX_ORIGIN));
      expect_result(vertex_out(r.f.c[1], n, TEX_RIGHT));
      expect_result(vertex_out(r.f.c[2], n, TEX_APEX));
      if (!is_tri) begin
         expect_result(vertex_out(r.f.c[2], n, TEX_ORIGIN));
         expect_result(vertex_out(r.f.c[3], n, TEX_RIGHT));
         expect_result(vertex_out(r.f.c[0], n, TEX_APEX));
      end
      bx.kind = KIND_BOX;
      bx.a = box_lo;
      bx.b = box_hi;
      bx.tex = TEX_ORIGIN;
      bx.last = 1'b1;
      expect_result(bx);
   endtask

   task automatic add_row(input int x0, y0, z0, x1, y1, z1, x2, y2, z2, x3, y3, z3,
                          input bit fx, input int nx = 0, ny = 0, nz = 0);
      row_type r;
      r.f.c[0] = '{coord_type'(x0), coord_type'(y0), coord_type'(z0)};
      r.f.c[1] = '{coord_type'(x1), coord_type'(y1), coord_type'(z1)};
      r.f.c[2] = '{coord_type'(x2), coord_type'(y2), coord_type'(z2)};
      r.f.c[3] = '{coord_type'(x3), coord_type'(y3), coord_type'(z3)};
      r.fixed = fx;
      r.nrm = '{coord_type'(nx), coord_type'(ny), coord_type'(nz)};
      face_rows = {face_rows, r};
   endtask

   function automatic coord_type rand_coord(int mode);
      case (mode)
         0: return coord_type'($urandom);
         1: return coord_type'(int'($urandom_range(0, 4000)) - 2000);
         default: return ($urandom_range(0, 1) != 0) ? coord_type'(24'h7fffff)
                                                     : coord_type'(24'h800000);
      endcase
   endfunction

   function automatic row_type rand_face();
      row_type r;
      int mode, shape;
      mode = $urandom_range(0, 9);
      mode = (mode < 5) ? 0 : (mode < 9) ? 1 : 2;
      shape = $urandom_range(0, 9);
      for (int c = 0; c < 4; c++)
         for (int i = 0; i < 3; i++)
            r.f.c[c][i] = rand_coord(($urandom_range(0, 7) == 0) ? 2 : mode);
      if (shape < 3) r.f.c[3] = r.f.c[2];
      else if (shape == 3) r.f.c[1] = r.f.c[0];
      else if (shape == 4) r.f.c[3] = r.f.c[0];
      else if (shape == 5) r.f.c[3][$urandom_range(0, 2)] = r.f.c[2][0];
      r.fixed = 1'b0;
      return r;
   endfunction

   // Sender: the directed table first, then random faces.
   initial begin
      int total, gap;
      row_type r;
      add_row(0, 0, 0, 256, 0, 0, 256, 256, 0, 0, 256, 0, 1, 0, 0, 16384);
      add_row(0, 0, 0, 0, 0, 256, 0, 256, 0, 0, 256, 0, 1, -16384, 0, 0);
      add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1);
      add_row(1, 1, 1, 2, 2, 2, 5, 0, 0, 3, 3, 3, 1);
      add_row(8388607, 8388607, 8388607, -8388608, -8388608, -8388608,
              8388607, -8388608, 0, 0, 8388607, -8388608, 0);
      add_row(-8388608, -8388608, -8388608, -8388608, -8388608, -8388608,
              -8388608, -8388608, -8388608, -8388608, -8388608, -8388608, 1);
      add_row(8388607, 8388607, 8388607, 8388607, 8388607, 8388607,
              8388607, 8388607, 8388607, 8388607, 8388607, 8388607, 1);
      add_row(-8388608, -8388608, -8388608, 8388607, -8388608, 0,
              0, 8388607, -8388608, 8388607, 8388607, 8388607, 0);
      add_row(0, 0, 0, 0, 0, -256, 300, 0, -300, 256, 0, 0, 0);
      add_row(10, 20, 30, 40, 25, 31, 10, 20, 30, 10, 20, 31, 0);
      add_row(10, 20, 30, 40, 25, 31, 10, 20, 30, 11, 20, 30, 0);
      add_row(0, 0, 0, 1, 0, 0, 1, 1, 0, 0, 1, 0, 1, 0, 0, 16384);
      add_row(-5, 7, -9, 12345, -678, 91011, -4000000, 3000000, 77, 5, -5, 5, 0);
      add_row(8388607, 0, -8388608, 0, 8388607, 0, 1, 1, 1, -8388608, 8388607, 0, 0);
      for (int j = 0; j < N_RANDOM; j++) face_rows = {face_rows, rand_face()};
      total = face_rows.size();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int j = 0; j < total; j++) begin
         r = face_rows[j];
         // Faces in the middle go back to back; one pause lets the block drain.
         gap = (j >= 40 && j < 60) ? 0 : $urandom_range(0, 18);
         if (j == 90) begin
            req_valid <= 1'b0;
            @(negedge clock);
            while (expected_out.size() != 0) @(negedge clock);
         end
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_valid <= 1'b1;
         req_c <= r.f.c;
         forever begin
            @(posedge clock);
            if (req_ready) break;
         end
         queue_face_results(r);
         @(negedge clock);
      end
      req_valid <= 1'b0;
      sending_done = 1'b1;
   end

   task automatic report(input string what, input vtx_out_type e, input vtx_out_type g);
      mismatches++;
      if (mismatches <= 10) begin
         $display("mismatch in %s:", what);
         $display("  expected kind %0d a %0d %0d %0d b %0d %0d %0d tex %0d last %0d",
                  e.kind, e.a[0], e.a[1], e.a[2], e.b[0], e.b[1], e.b[2], e.tex, e.last);
         $display("  got      kind %0d a %0d %0d %0d b %0d %0d %0d tex %0d last %0d",
                  g.kind, g.a[0], g.a[1], g.a[2], g.b[0], g.b[1], g.b[2], g.tex, g.last);
      end
   endtask

   // Receiver: a random hold-off before each result but results 250 to 349,
   // and one long one that lets the input side fill up.
   initial begin
      int hold;
      vtx_out_type got, exp_v;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         hold = (results_taken >= 250 && results_taken < 350) ? 0 : $urandom_range(0, 18);
         if (results_taken == 30) hold = 600;
         if (hold != 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         forever begin
            @(posedge clock);
            if (rsp_valid) break;
         end
         got.kind = rsp_kind;
         got.a = '{coord_type'(rsp_a_x), coord_type'(rsp_a_y), coord_type'(rsp_a_z)};
         got.b = '{coord_type'(rsp_b_x), coord_type'(rsp_b_y), coord_type'(rsp_b_z)};
         got.tex = rsp_tex_corner;
         got.last = rsp_last;
         results_taken++;
         if (expected_out.size() == 0) begin
            exp_v = '{default: '0, a: '{default: '0}, b: '{default: '0}};
            report("unexpected transaction", exp_v, got);
         end else begin
            exp_v = expected_out.pop_front();
            if (got.kind !== exp_v.kind) report("kind", exp_v, got);
            else if (got.a != exp_v.a) report("position or box minimum", exp_v, got);
            else if (got.b != exp_v.b) report("normal or box maximum", exp_v, got);
            else if (got.tex !== exp_v.tex) report("tex_corner", exp_v, got);
            else if (got.last !== exp_v.last) report("last", exp_v, got);
         end
         @(negedge clock);
      end
   end

   initial begin
      @(negedge clock);
      while (!sending_done || expected_out.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      if (mismatches == 0 && expected_out.size() == 0)
         $display("face_triangulate_normal_bbox test passed");
      else
         $display("face_triangulate_normal_bbox test failed");
      $finish;
   end

endmodule

// ===== files.f =====
design/ftnb_pkg.sv
design/ftnb_front.sv
design/ftnb_fifo.sv
design/ftnb_normal.sv
design/ftnb_back.sv
design/face_triangulate_normal_bbox.sv
bench/tb_face_triangulate_normal_bbox.sv
